@@ hw/rtl/grid_region_first_fit_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid region allocator
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_REGION_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define GRID_REGION_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Property holds in the same cycle.
`define GRFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define GRFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/grfa_pkg.sv @@
// ----------------------------------------------------------------------------
// grfa_pkg
// Types and constants shared by the grid region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package grfa_pkg;

  localparam int GridColsDef = 16;
  localparam int GridRowsDef = 512;

  // internal arithmetic widths, wide enough for any built grid size
  localparam int ColCalcW = 7;
  localparam int RowCalcW = 13;

  localparam logic CfgColsIdx = 1'b0;
  localparam logic CfgRowsIdx = 1'b1;

  typedef struct packed {
    logic [4:0] want_width;
    logic [9:0] want_height;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] origin_col;
    logic [8:0] origin_row;
    logic [4:0] got_width;
    logic [9:0] got_height;
    logic [8:0] top_used_row;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic chk;
    logic sweep;
    logic mark_init;
    logic mark_rd;
    logic mark_wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_zero;
    logic chk_last;
    logic sw_fit;
    logic sw_last_x;
    logic last_y;
    logic have_best;
    logic mark_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/grid_region_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// grid_region_first_fit_allocator
// First-fit rectangle allocator over a cell occupancy grid.
// ----------------------------------------------------------------------------
// One request at a time. After reset the occupancy memory is cleared in a pass
// over all GridRows rows (512 by default) before the first request is taken. A
// request walks the rows in use; for each row it reads rows from there down
// (one memory port), stopping once every anchor lane is blocked or the
// rectangle height is covered, then sweeps the anchor columns one per cycle.
// The result sits in an output register, so a new request is taken while it
// waits.
`default_nettype none

module grid_region_first_fit_allocator #(
  parameter int GridCols = grfa_pkg::GridColsDef,
  parameter int GridRows = grfa_pkg::GridRowsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [9:0]     cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire grfa_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output grfa_pkg::rsp_t      out_data_o
);

  grfa_pkg::cmd_t cmd;
  grfa_pkg::sts_t sts;

  grfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grfa_dp #(
    .GridCols (GridCols),
    .GridRows (GridRows)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

@@ hw/rtl/grfa_ram.sv @@
// ----------------------------------------------------------------------------
// grfa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grfa_ram #(
  parameter int Width = 16,
  parameter int Depth = 512,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/grfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// grfa_ctrl
// Sequencer: clearing pass, row checks, anchor sweep, marking, result.
// ----------------------------------------------------------------------------
`default_nettype none

module grfa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire grfa_pkg::sts_t sts_i,
  output grfa_pkg::cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_SWEEP = 9'b000010000,
    S_MINIT = 9'b000100000,
    S_MRD   = 9'b001000000,
    S_MWR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.req_zero ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.chk_last ? S_SWEEP : S_RD;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sw_fit) begin
          state_d = S_MINIT;
        end else if (sts_i.sw_last_x) begin
          if (!sts_i.last_y) state_d = S_RD;
          else state_d = sts_i.have_best ? S_MINIT : S_DONE;
        end
      end
      S_MINIT: begin
        cmd_o.mark_init = 1'b1;
        state_d         = S_MRD;
      end
      S_MRD: begin
        cmd_o.mark_rd = 1'b1;
        state_d       = S_MWR;
      end
      S_MWR: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = sts_i.mark_last ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/grfa_dp.sv @@
// ----------------------------------------------------------------------------
// grfa_dp
// Occupancy memory, per-column anchor lanes, best-region tracking, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_region_first_fit_allocator_macros.svh"

module grfa_dp #(
  parameter int GridCols = grfa_pkg::GridColsDef,
  parameter int GridRows = grfa_pkg::GridRowsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [9:0]     cfg_wdata_i,
  input  wire grfa_pkg::req_t in_data_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output grfa_pkg::rsp_t      out_data_o,
  input  wire grfa_pkg::cmd_t cmd_i,
  output grfa_pkg::sts_t      sts_o
);

  localparam int CW    = grfa_pkg::ColCalcW;
  localparam int RW    = grfa_pkg::RowCalcW;
  localparam int LaneW = (GridCols > 1) ? $clog2(GridCols) : 1;
  localparam int AddrW = (GridRows > 1) ? $clog2(GridRows) : 1;
  localparam int AreaW = CW + RW;
  localparam logic [CW-1:0] ColsMax = CW'(GridCols);
  localparam logic [RW-1:0] RowsMax = RW'(GridRows);

  // configuration
  logic [CW-1:0] cols_q, cfg_cols;
  logic [RW-1:0] rows_q, cfg_rows;

  always_comb begin
    cfg_cols = CW'(cfg_wdata_i[4:0]);
    if (cfg_cols == '0) cfg_cols = CW'(1);
    if (cfg_cols > ColsMax) cfg_cols = ColsMax;
    cfg_rows = RW'(cfg_wdata_i);
    if (cfg_rows == '0) cfg_rows = RW'(1);
    if (cfg_rows > RowsMax) cfg_rows = RowsMax;
  end

  // request and scan state
  logic [CW-1:0]    w_q, x_q, bx_q, bw_q;
  logic [RW-1:0]    h_q, y_q, ry_q, by_q, bh_q, highest_q;
  logic [AreaW-1:0] barea_q;
  logic             out_valid_q;
  grfa_pkg::rsp_t   out_q;

  logic [GridCols-1:0] alive_q, blk_q, nxt_alive, nxt_blk;
  logic [CW-1:0]       cwid_q [GridCols];
  logic [RW-1:0]       chgt_q [GridCols];
  logic [CW-1:0]       lane_cwid [GridCols];

  logic [GridCols-1:0] rd_data, wr_data, mark_mask;
  logic [CW-1:0]       req_w;
  logic [RW-1:0]       req_h, ch, row_span;
  logic                first;

  always_comb begin
    req_w = CW'(in_data_i.want_width);
    if (req_w > ColsMax) req_w = ColsMax;
    req_h = RW'(in_data_i.want_height);
    if (req_h > RowsMax) req_h = RowsMax;
  end

  assign ch       = (h_q < (rows_q - y_q)) ? h_q : (rows_q - y_q);
  assign first    = (ry_q == y_q);
  assign row_span = ry_q - y_q + RW'(1);

  // one lane per anchor column of the current row
  for (genvar gx = 0; gx < GridCols; gx++) begin : g_lane
    logic [CW-1:0]       cw_x;
    logic [GridCols-1:0] mask_x, hit_x;
    logic [CW-1:0]       lb_x;
    logic                free_x, act_x;

    assign cw_x = (w_q < (cols_q - CW'(gx))) ? w_q : (cols_q - CW'(gx));

    always_comb begin
      for (int b = 0; b < GridCols; b++) begin
        mask_x[b] = (CW'(b) >= CW'(gx)) && (CW'(b) < (CW'(gx) + cw_x));
      end
    end

    assign hit_x  = rd_data & mask_x;
    assign free_x = !rd_data[gx] && (CW'(gx) < cols_q);

    always_comb begin
      lb_x = '0;
      for (int b = GridCols - 1; b >= 0; b--) begin
        if (hit_x[b]) lb_x = CW'(b);
      end
    end

    assign nxt_alive[gx] = first ? free_x : alive_q[gx];
    assign act_x         = nxt_alive[gx] && (first ? 1'b1 : !blk_q[gx]);
    assign nxt_blk[gx]   = (first ? 1'b0 : blk_q[gx]) || (act_x && (hit_x != '0));
    assign lane_cwid[gx] = lb_x - CW'(gx);

    always_ff @(posedge clk_i) begin
      if (cmd_i.chk && act_x && (hit_x != '0)) begin
        cwid_q[gx] <= lane_cwid[gx];
        chgt_q[gx] <= row_span;
      end
    end
  end

  // sweep over anchors of the current row, one per cycle
  logic [LaneW-1:0] sel;
  logic [CW-1:0]    cw_sel;
  logic [AreaW-1:0] area_sel;
  logic             better, fit;

  assign sel      = x_q[LaneW-1:0];
  assign cw_sel   = (w_q < (cols_q - x_q)) ? w_q : (cols_q - x_q);
  assign area_sel = AreaW'(cwid_q[sel]) * AreaW'(chgt_q[sel]);
  assign better   = alive_q[sel] && blk_q[sel] && (area_sel > barea_q);
  assign fit      = alive_q[sel] && !blk_q[sel] && (ch == h_q) && (cw_sel == w_q);

  always_comb begin
    for (int b = 0; b < GridCols; b++) begin
      mark_mask[b] = (CW'(b) >= bx_q) && (CW'(b) < (bx_q + bw_q));
    end
  end

  assign wr_data = cmd_i.clr ? '0 : (rd_data | mark_mask);

  grfa_ram #(
    .Width (GridCols),
    .Depth (GridRows)
  ) u_occ_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.clr || cmd_i.mark_wr),
    .wr_addr_i (ry_q[AddrW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd || cmd_i.mark_rd),
    .rd_addr_i (ry_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= ColsMax;
      rows_q      <= RowsMax;
      ry_q        <= '0;
      highest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == grfa_pkg::CfgColsIdx)) cols_q <= cfg_cols;
      if (cfg_we_i && (cfg_idx_i == grfa_pkg::CfgRowsIdx)) rows_q <= cfg_rows;
      if (cmd_i.clr || cmd_i.chk || cmd_i.mark_wr) ry_q <= ry_q + RW'(1);
      if (cmd_i.load) ry_q <= '0;
      if (cmd_i.sweep && !fit && (x_q == cols_q - CW'(1))) ry_q <= y_q + RW'(1);
      if (cmd_i.mark_init) begin
        ry_q <= by_q;
        if ((by_q + bh_q - RW'(1)) > highest_q) highest_q <= by_q + bh_q - RW'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q     <= req_w;
      h_q     <= req_h;
      y_q     <= '0;
      x_q     <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      barea_q <= '0;
    end
    if (cmd_i.chk) begin
      alive_q <= nxt_alive;
      blk_q   <= nxt_blk;
      x_q     <= '0;
    end
    if (cmd_i.sweep) begin
      x_q <= x_q + CW'(1);
      if (fit) begin
        bx_q <= x_q;
        by_q <= y_q;
        bw_q <= cw_sel;
        bh_q <= ch;
      end else if (better) begin
        bx_q    <= x_q;
        by_q    <= y_q;
        bw_q    <= cwid_q[sel];
        bh_q    <= chgt_q[sel];
        barea_q <= area_sel;
      end
      if (!fit && (x_q == cols_q - CW'(1))) y_q <= y_q + RW'(1);
    end
    if (cmd_i.emit) begin
      out_q.granted      <= (bw_q != '0);
      out_q.origin_col   <= bx_q[3:0];
      out_q.origin_row   <= by_q[8:0];
      out_q.got_width    <= bw_q[4:0];
      out_q.got_height   <= bh_q[9:0];
      out_q.top_used_row <= highest_q[8:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = (ry_q == RowsMax - RW'(1));
    sts_o.req_zero  = (in_data_i.want_width == '0) || (in_data_i.want_height == '0);
    sts_o.chk_last  = (row_span == ch) || ((nxt_alive & ~nxt_blk) == '0);
    sts_o.sw_fit    = fit;
    sts_o.sw_last_x = (x_q == cols_q - CW'(1));
    sts_o.last_y    = (y_q == rows_q - RW'(1));
    sts_o.have_best = (bw_q != '0) || better;
    sts_o.mark_last = ((ry_q - by_q + RW'(1)) == bh_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  `GRFA_ASSERT(a_chk_in_grid, clk_i, rst_ni, !cmd_i.chk || (ry_q < rows_q), "row check beyond grid")
  `GRFA_ASSERT_NEXT(a_emit_size, clk_i, rst_ni, cmd_i.emit && (bw_q != '0), out_q.granted && (out_q.got_height != '0), "granted region has no height")
  `GRFA_ASSERT_NEXT(a_top_row, clk_i, rst_ni, cmd_i.mark_init, highest_q >= $past(by_q + bh_q - RW'(1)), "top used row below marked region")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Grid region allocator testbench
// Drives rectangle requests through several grid sizes. A model of the
// occupancy bitmap predicts every response, and each response is checked
// against it as a whole.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int NCols = 16;
  localparam int NRows = 512;
  localparam int CycleLimit = 6000000;
  localparam int HoldAt = 150;
  localparam int HoldLen = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = grfa_pkg::CfgColsIdx;
  logic [9:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  grfa_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  grfa_pkg::rsp_t out_data_o;

  grid_region_first_fit_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [15:0] occ_map [NRows];
  int unsigned top_row;
  int unsigned cols_cur;
  int unsigned rows_cur;

  grfa_pkg::req_t pending_reqs[$];
  grfa_pkg::rsp_t grants_due[$];
  int   n_errors = 0;
  bit   idle_on = 1'b1;
  int   cycles = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] span(int unsigned first, int unsigned cnt);
    logic [31:0] m;
    m = (32'd1 << cnt) - 32'd1;
    return 16'(m << first);
  endfunction

  // first-fit search and marking, returns the response the block must give
  function automatic grfa_pkg::rsp_t allocate(grfa_pkg::req_t rq);
    int unsigned w, h, bx, by, bw, bh, cw, ch, lb, cwid, chgt;
    logic [15:0] msk, hit;
    bit done, blocked;
    grfa_pkg::rsp_t r;
    w = clamp(rq.want_width, 0, NCols);
    h = clamp(rq.want_height, 0, NRows);
    bx = 0; by = 0; bw = 0; bh = 0;
    done = 1'b0;
    for (int unsigned y = 0; y < rows_cur && !done; y++) begin
      for (int unsigned x = 0; x < cols_cur && !done; x++) begin
        if (occ_map[y][x]) continue;
        ch = (rows_cur - y < h) ? rows_cur - y : h;
        cw = (cols_cur - x < w) ? cols_cur - x : w;
        msk = span(x, cw);
        blocked = 1'b0;
        for (int unsigned ry = y; ry < y + ch; ry++) begin
          hit = occ_map[ry] & msk;
          if (hit != 0) begin
            lb = 0;
            while (lb < 15 && !hit[lb]) lb++;
            cwid = lb - x;
            chgt = ry + 1 - y;
            if (cwid * chgt > bw * bh) begin
              bx = x; by = y; bw = cwid; bh = chgt;
            end
            blocked = 1'b1;
            break;
          end
        end
        if (!blocked && ch == h && cw == w) begin
          bx = x; by = y; bw = cw; bh = ch;
          done = 1'b1;
        end
      end
    end
    r = '0;
    if (bw != 0 && bh != 0) begin
      msk = span(bx, bw);
      for (int unsigned ry = by; ry < by + bh && ry < NRows; ry++) occ_map[ry] |= msk;
      if (by + bh - 1 > top_row) top_row = by + bh - 1;
      r.granted = 1'b1;
      r.origin_col = 4'(bx);
      r.origin_row = 9'(by);
      r.got_width = 5'(bw);
      r.got_height = 10'(bh);
    end
    r.top_used_row = 9'(top_row);
    return r;
  endfunction

  // request driver
  int gap_left = 0;
  always @(posedge clk_i) begin
    bit nxt_valid;
    grfa_pkg::req_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data = in_data_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        grants_due.insert(grants_due.size(), allocate(in_data_i));
        nxt_valid = 1'b0;
        gap_left = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) gap_left--;
        else if (pending_reqs.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data = pending_reqs.pop_front();
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i <= nxt_data;
  end

  // one long receiver hold-off to back the block up
  int   hold_beats = 0;
  int   hold_cnt = 0;
  logic holding = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) hold_beats++;
      if (holding) begin
        hold_cnt++;
        if (hold_cnt >= HoldLen) holding <= 1'b0;
      end else if (hold_beats == HoldAt && hold_cnt == 0) begin
        holding <= 1'b1;
      end
    end
  end

  // response monitor
  int stall_left = 0;
  always @(posedge clk_i) begin
    grfa_pkg::rsp_t want;
    bit nxt_ready;
    nxt_ready = out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (grants_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected response %p", out_data_o);
        end else begin
          want = grants_due.pop_front();
          if (out_data_o !== want) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, out_data_o);
          end
        end
        stall_left = idle_on ? $urandom_range(0, 15) : 0;
        nxt_ready = 1'b0;
      end
      if (holding) begin
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else nxt_ready = 1'b1;
    end
    out_ready_i <= nxt_ready;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || grants_due.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == grfa_pkg::CfgColsIdx) cols_cur = clamp(val[4:0], 1, NCols);
    else cols_cur = cols_cur;
    if (idx == grfa_pkg::CfgRowsIdx) rows_cur = clamp(val, 1, NRows);
  endtask

  task automatic set_grid(logic [9:0] cols_raw, logic [9:0] rows_raw);
    drain();
    write_reg(grfa_pkg::CfgColsIdx, cols_raw);
    write_reg(grfa_pkg::CfgRowsIdx, rows_raw);
  endtask

  function automatic grfa_pkg::req_t mk(int unsigned w, int unsigned h);
    grfa_pkg::req_t r;
    r.want_width = 5'(w);
    r.want_height = 10'(h);
    return r;
  endfunction

  function automatic void add_req(int unsigned w, int unsigned h);
    pending_reqs.insert(pending_reqs.size(), mk(w, h));
  endfunction

  // mostly in-range sizes, with some zero and saturating ones
  task automatic queue_random(int n, int hmax, bit tall_ok);
    int unsigned w, h, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) w = $urandom_range(17, 31);
      else if (pick == 1) w = 0;
      else w = $urandom_range(1, cols_cur);
      pick = $urandom_range(0, 29);
      if (pick == 0 && tall_ok) h = $urandom_range(513, 1023);
      else if (pick == 1) h = 0;
      else h = $urandom_range(1, hmax);
      add_req(w, h);
    end
  endtask

  initial begin
    for (int i = 0; i < NRows; i++) occ_map[i] = '0;
    top_row = 0;
    cols_cur = NCols;
    rows_cur = NRows;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // occupancy clearing pass runs before the first request is taken
    do @(posedge clk_i); while (!in_ready_o);

    // directed: zero sizes, saturation, exact fits, partial fallbacks
    set_grid(10'd16, 10'd8);
    add_req(0, 0);
    add_req(0, 5);
    add_req(5, 0);
    add_req(4, 2);
    add_req(31, 1);
    add_req(16, 1);
    add_req(3, 1023);
    add_req(6, 6);
    add_req(16, 8);
    add_req(1, 1);
    add_req(2, 3);
    add_req(16, 512);
    add_req(1, 1);
    set_grid(10'd0, 10'd0);          // both clamp up to one cell
    add_req(1, 1);
    add_req(1, 1);
    set_grid(10'd31, 10'd12);        // cols clamps to the built width
    add_req(16, 512);
    add_req(10, 2);
    add_req(21, 682);

    idle_on = 1'b1;
    queue_random(60, 12, 1'b1);
    set_grid(10'd7, 10'd20);
    idle_on = 1'b0;
    queue_random(70, 12, 1'b1);
    set_grid(10'd16, 10'd32);
    idle_on = 1'b1;
    queue_random(100, 10, 1'b1);
    set_grid(10'd5, 10'd48);
    queue_random(80, 8, 1'b0);
    set_grid(10'd16, 10'd96);
    idle_on = 1'b0;
    queue_random(90, 6, 1'b0);
    set_grid(10'd16, 10'd1023);      // rows clamps to the built height
    idle_on = 1'b1;
    queue_random(10, 2, 1'b0);
    set_grid(10'd9, 10'd128);
    queue_random(80, 4, 1'b0);
    set_grid(10'd1, 10'd140);
    queue_random(60, 8, 1'b0);
    drain();

    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && grants_due.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/grfa_pkg.sv
hw/rtl/grfa_ram.sv
hw/rtl/grfa_ctrl.sv
hw/rtl/grfa_dp.sv
hw/rtl/grid_region_first_fit_allocator.sv
test/tb.sv
